@@ hw/rtl/llf_pkg.sv @@
package llf_pkg;

  // Sample format: signed fixed point with FRAC_BITS fractional bits.
  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W  = 32;

  // Coefficient register widths.
  localparam int POLE_W = 18;  // unsigned
  localparam int FB_W   = 19;  // signed
  localparam int RES_W  = 32;  // signed
  localparam int CFG_W  = RES_W;
  localparam int CFG_IDX_W = 2;

  localparam int STAGES      = 4;
  localparam int STAGE_IDX_W = 2;

  // Shared multiplier: signed operands one bit wider than the widest value.
  localparam int MUL_W  = ((SAMPLE_W > RES_W) ? SAMPLE_W : RES_W) + 1;
  localparam int PROD_W = 2 * MUL_W;

  // Division of the cubic term by six is done as a multiply by a rounded-up
  // reciprocal followed by a shift; exact for magnitudes below 2**SAMPLE_W.
  localparam int FIX16_6      = 6;
  localparam int RECIP_SHIFT  = SAMPLE_W + 2;
  localparam logic [63:0] RECIP_6 =
    ((64'd1 << RECIP_SHIFT) + 64'(FIX16_6 - 1)) / 64'(FIX16_6);

  // Sequencer length: steps 0 to STEP_LAST of one filtered sample.
  localparam int STEP_LAST = 18;
  localparam int STEP_W    = $clog2(STEP_LAST + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE         = 2'd0,
    CFG_POLE_GAIN      = 2'd1,
    CFG_STAGE_FEEDBACK = 2'd2,
    CFG_RESONANCE_GAIN = 2'd3
  } cfg_reg_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE      = 3'd0,
    MUL_R_S3      = 3'd1,
    MUL_PIN_P     = 3'd2,
    MUL_ACC_P     = 3'd3,
    MUL_K_ST      = 3'd4,
    MUL_ACC_ACC   = 3'd5,
    MUL_PROD_ACC  = 3'd6,
    MUL_ABS_RECIP = 3'd7
  } mul_sel_t;

  // Operation on the accumulator using the scaled product or the quotient.
  typedef enum logic [2:0] {
    ACC_NONE  = 3'd0,
    ACC_X     = 3'd1,
    ACC_LOAD  = 3'd2,
    ACC_ADD   = 3'd3,
    ACC_SUB   = 3'd4,
    ACC_CUBE  = 3'd5,
    ACC_FINAL = 3'd6
  } acc_op_t;

  typedef struct packed {
    mul_sel_t                mul_sel;
    logic [STAGE_IDX_W-1:0]  mul_idx;
    acc_op_t                 acc_op;
    logic                    st_en;
    logic [STAGE_IDX_W-1:0]  st_idx;
    logic                    load_in;
    logic                    load_out;
  } llf_cmd_t;

  typedef struct packed {
    logic enable;
  } llf_status_t;

endpackage

@@ hw/rtl/llf_datapath.sv @@
module llf_datapath import llf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic signed [SAMPLE_W-1:0] sample_out,
  input  llf_cmd_t                   cmd,
  output llf_status_t                status
);

  logic                       cfg_enable;
  logic [POLE_W-1:0]          pole_gain;
  logic signed [FB_W-1:0]     stage_feedback;
  logic signed [RES_W-1:0]    resonance_gain;

  logic signed [SAMPLE_W-1:0] st [STAGES];
  logic signed [SAMPLE_W-1:0] pin [STAGES];
  logic signed [SAMPLE_W-1:0] acc;
  logic signed [SAMPLE_W-1:0] acc_next;
  logic signed [SAMPLE_W-1:0] pf;
  logic signed [SAMPLE_W-1:0] q;
  logic [SAMPLE_W-1:0]        cabs;
  logic                       csign;
  logic [MUL_W-1:0]           op_a;
  logic [MUL_W-1:0]           op_b;
  logic signed [PROD_W-1:0]   prod;
  logic [STAGE_IDX_W-1:0]     pin_wr_idx;
  logic                       pin_wr_ok;

  function automatic logic [MUL_W-1:0] sx_smp(input logic [SAMPLE_W-1:0] v);
    return {{(MUL_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  assign status.enable = cfg_enable;

  // Product scaled back to the sample format and wrapped.
  assign pf = prod[FRAC_BITS +: SAMPLE_W];
  // Quotient of the cubic term magnitude by six.
  assign q  = prod[RECIP_SHIFT +: SAMPLE_W];

  assign pin_wr_idx = cmd.st_idx + STAGE_IDX_W'(1);
  assign pin_wr_ok  = (cmd.st_idx != STAGE_IDX_W'(STAGES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_enable     <= 1'b0;
      pole_gain      <= '0;
      stage_feedback <= '0;
      resonance_gain <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ENABLE:         cfg_enable     <= cfg_data[0];
        CFG_POLE_GAIN:      pole_gain      <= cfg_data[POLE_W-1:0];
        CFG_STAGE_FEEDBACK: stage_feedback <= cfg_data[FB_W-1:0];
        CFG_RESONANCE_GAIN: resonance_gain <= cfg_data[RES_W-1:0];
        default:            cfg_enable     <= cfg_enable;
      endcase
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.mul_sel)
      MUL_R_S3: begin
        op_a = {{(MUL_W - RES_W){resonance_gain[RES_W-1]}}, resonance_gain};
        op_b = sx_smp(st[STAGES-1]);
      end
      MUL_PIN_P: begin
        op_a = sx_smp(pin[cmd.mul_idx]);
        op_b = {{(MUL_W - POLE_W){1'b0}}, pole_gain};
      end
      MUL_ACC_P: begin
        op_a = sx_smp(acc);
        op_b = {{(MUL_W - POLE_W){1'b0}}, pole_gain};
      end
      MUL_K_ST: begin
        op_a = {{(MUL_W - FB_W){stage_feedback[FB_W-1]}}, stage_feedback};
        op_b = sx_smp(st[cmd.mul_idx]);
      end
      MUL_ACC_ACC: begin
        op_a = sx_smp(acc);
        op_b = sx_smp(acc);
      end
      MUL_PROD_ACC: begin
        op_a = sx_smp(pf);
        op_b = sx_smp(acc);
      end
      MUL_ABS_RECIP: begin
        op_a = {{(MUL_W - SAMPLE_W){1'b0}}, cabs};
        op_b = MUL_W'(RECIP_6);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.acc_op)
      ACC_X:     acc_next = acc - pf;
      ACC_LOAD:  acc_next = pf;
      ACC_ADD:   acc_next = acc + pf;
      ACC_SUB:   acc_next = acc - pf;
      ACC_FINAL: acc_next = csign ? (acc + q) : (acc - q);
      default:   acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        st[i]  <= '0;
        pin[i] <= '0;
      end
    end else begin
      if (cmd.acc_op == ACC_X) begin
        pin[0] <= acc_next;
      end
      if (cmd.st_en) begin
        st[cmd.st_idx] <= acc_next;
        if (pin_wr_ok) begin
          pin[pin_wr_idx] <= acc_next;
        end
      end
      if (cmd.acc_op == ACC_FINAL) begin
        st[STAGES-1] <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      acc <= sample_in;
    end else begin
      acc <= acc_next;
    end
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= $signed(op_a) * $signed(op_b);
    end
    if (cmd.acc_op == ACC_CUBE) begin
      csign <= pf[SAMPLE_W-1];
      cabs  <= pf[SAMPLE_W-1] ? (-pf) : pf;
    end
    if (cmd.load_out) begin
      sample_out <= acc;
    end
  end

endmodule

@@ hw/rtl/llf_ctrl.sv @@
module llf_ctrl import llf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  llf_status_t status,
  output llf_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [STEP_W-1:0]   step;
  logic [STEP_W-1:0]   step_next;
  logic                out_valid_next;
  logic                accept;
  logic                slot_free;

  // Fixed schedule of one filtered sample. A product issued in a step is
  // used in the next step by the accumulator, multiplier or cube register.
  function automatic llf_cmd_t run_cmd(input logic [STEP_W-1:0] s);
    llf_cmd_t c;
    c = '0;
    case (s)
      0:  c.mul_sel = MUL_R_S3;
      1:  begin
        c.mul_sel = MUL_PIN_P;  c.mul_idx = STAGE_IDX_W'(0); c.acc_op = ACC_X;
      end
      2:  begin c.mul_sel = MUL_ACC_P; c.acc_op = ACC_LOAD; end
      3:  begin
        c.mul_sel = MUL_K_ST;   c.mul_idx = STAGE_IDX_W'(0); c.acc_op = ACC_ADD;
      end
      4:  begin
        c.mul_sel = MUL_PIN_P;  c.mul_idx = STAGE_IDX_W'(1); c.acc_op = ACC_SUB;
        c.st_en   = 1'b1;       c.st_idx  = STAGE_IDX_W'(0);
      end
      5:  begin c.mul_sel = MUL_ACC_P; c.acc_op = ACC_LOAD; end
      6:  begin
        c.mul_sel = MUL_K_ST;   c.mul_idx = STAGE_IDX_W'(1); c.acc_op = ACC_ADD;
      end
      7:  begin
        c.mul_sel = MUL_PIN_P;  c.mul_idx = STAGE_IDX_W'(2); c.acc_op = ACC_SUB;
        c.st_en   = 1'b1;       c.st_idx  = STAGE_IDX_W'(1);
      end
      8:  begin c.mul_sel = MUL_ACC_P; c.acc_op = ACC_LOAD; end
      9:  begin
        c.mul_sel = MUL_K_ST;   c.mul_idx = STAGE_IDX_W'(2); c.acc_op = ACC_ADD;
      end
      10: begin
        c.mul_sel = MUL_PIN_P;  c.mul_idx = STAGE_IDX_W'(3); c.acc_op = ACC_SUB;
        c.st_en   = 1'b1;       c.st_idx  = STAGE_IDX_W'(2);
      end
      11: begin c.mul_sel = MUL_ACC_P; c.acc_op = ACC_LOAD; end
      12: begin
        c.mul_sel = MUL_K_ST;   c.mul_idx = STAGE_IDX_W'(3); c.acc_op = ACC_ADD;
      end
      13: c.acc_op  = ACC_SUB;
      14: c.mul_sel = MUL_ACC_ACC;
      15: c.mul_sel = MUL_PROD_ACC;
      16: c.acc_op  = ACC_CUBE;
      17: c.mul_sel = MUL_ABS_RECIP;
      18: c.acc_op  = ACC_FINAL;
      default: c = '0;
    endcase
    return c;
  endfunction

  always_comb begin
    in_stall   = (state != ST_IDLE);
    accept     = in_valid && !in_stall;
    slot_free  = !out_valid || !out_stall;
    cmd        = '0;
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          step_next   = '0;
          state_next  = status.enable ? ST_RUN : ST_WRITE;
        end
      end
      ST_RUN: begin
        cmd = run_cmd(step);
        if (step == STEP_W'(STEP_LAST)) begin
          state_next = ST_WRITE;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_WRITE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ hw/rtl/ladder_lowpass_filter.sv @@
// Four-pole resonant ladder low-pass filter on signed 16.16 samples. Each
// request carries one sample and yields exactly one filtered sample, in
// order. The sample first has resonance_gain times the last stage output
// subtracted from it, then passes through four one-pole sections of the
// form in * p + prev_in * p - k * state, and the fourth section is soft
// clipped with y - y*y*y/6. All products are floored after the 16-bit
// fractional shift and all sums wrap at 32 bits. With enable low the
// sample is returned unchanged and the filter state is left alone. The
// user must write the coefficients through the configuration port only
// while no sample is in flight; the block does not enforce this. The
// stage state resets to zero. One sample is processed at a time: the
// next is accepted only once the last result is in the output register,
// a hand-over that waits while an earlier result is stalled. With the
// filter enabled the single shared multiplier forms the sixteen products
// of the sample one after another in the nineteen sequencer steps. The
// output register holds a finished result while the next is accepted.
module ladder_lowpass_filter import llf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  // The controller steps through the fixed schedule and drives one command
  // per cycle; the datapath holds the coefficients, the stage state, the
  // shared multiplier and the accumulator.
  llf_cmd_t    cmd;
  llf_status_t status;

  llf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  llf_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .sample_out (sample_out),
    .cmd        (cmd),
    .status     (status)
  );

`ifndef NO_ASSERTIONS
  // A new result never overwrites one that is still waiting downstream.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  // The sample is captured only on an accepted request.
  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |-> (in_valid && !in_stall))
    else $error("sample captured without an accepted request");

  // After a request is accepted the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while the previous one is in flight");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import llf_pkg::*; ();

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Bit-exact software copy of the ladder filter. It keeps its own coefficient
  // registers and stage state, computes the expected sample for every request
  // that the block accepts, and compares each output with the oldest one.
  class ladder_scoreboard;
    bit                       enable;
    logic [POLE_W-1:0]        pole_gain;
    logic signed [FB_W-1:0]   stage_feedback;
    logic signed [RES_W-1:0]  resonance_gain;
    sample_t                  stage_value[STAGES];
    sample_t                  stage_prev_in[STAGES];
    sample_t                  expected_samples[$];
    int                       mismatches;
    int                       compared;
    int                       filtered;
    int                       passed_through;

    function new();
      enable         = 1'b0;
      pole_gain      = '0;
      stage_feedback = '0;
      resonance_gain = '0;
      foreach (stage_value[i]) begin
        stage_value[i]   = '0;
        stage_prev_in[i] = '0;
      end
    endfunction

    // Register writes keep only the low bits of the data, as the block does.
    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_ENABLE:         enable         = data[0];
        CFG_POLE_GAIN:      pole_gain      = data[POLE_W-1:0];
        CFG_STAGE_FEEDBACK: stage_feedback = data[FB_W-1:0];
        CFG_RESONANCE_GAIN: resonance_gain = data[RES_W-1:0];
        default: ;
      endcase
    endfunction

    // Exact product, floored by the fractional shift, wrapped to sample width.
    function sample_t mul_frac(longint a, longint b);
      longint prod;
      prod = a * b;
      return sample_t'(prod >>> FRAC_BITS);
    endfunction

    function void note_sample(sample_t x);
      longint  p, k, r;
      sample_t x_fb, feed, y, cube;
      sample_t nxt[STAGES];
      if (!enable) begin
        passed_through++;
        expected_samples.push_back(x);
      end else begin
        filtered++;
        p = longint'(pole_gain);
        k = longint'(stage_feedback);
        r = longint'(resonance_gain);
        // Global resonance feedback from the last stage output.
        x_fb = sample_t'(longint'(x) - longint'(mul_frac(r, stage_value[STAGES-1])));
        feed = x_fb;
        for (int i = 0; i < STAGES; i++) begin
          nxt[i] = sample_t'(longint'(mul_frac(feed, p))
                             + longint'(mul_frac(stage_prev_in[i], p))
                             - longint'(mul_frac(k, stage_value[i])));
          feed = nxt[i];
        end
        // Soft clip of the last stage: the square is wrapped before the cube,
        // and the division by six truncates toward zero.
        y    = nxt[STAGES-1];
        cube = mul_frac(mul_frac(y, y), y);
        y    = sample_t'(longint'(y) - longint'(cube) / FIX16_6);
        nxt[STAGES-1] = y;
        stage_prev_in[0] = x_fb;
        for (int i = 1; i < STAGES; i++) stage_prev_in[i] = nxt[i-1];
        for (int i = 0; i < STAGES; i++) stage_value[i] = nxt[i];
        expected_samples.push_back(y);
      end
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("output sample %h arrived with nothing pending", got);
      end else begin
        want = expected_samples.pop_front();
        compared++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample %0d: expected %h, got %h", compared, want, got);
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  localparam int LIMIT       = 1500000;
  localparam int TARGET_REQS = 1950;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  sample_t              sample_in;
  logic                 out_valid;
  logic                 out_stall;
  sample_t              sample_out;

  ladder_scoreboard sb;
  int  cycle_count;
  int  settings_count;
  int  sent;
  // When set, neither side inserts gaps or stalls, so back-to-back requests
  // are exercised as well.
  bit  steady;

  ladder_lowpass_filter u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly audio-sized values, with full-range words and the extremes mixed in.
  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return sample_t'(int'($urandom_range(0, 32'h40000)) - 32'sh20000);
    if (r < 75) return sample_t'(int'($urandom_range(0, 32'h1000000)) - 32'sh800000);
    if (r < 87) return sample_t'($urandom);
    if (r < 93) return '0;
    if (r < 97) return sample_t'(32'h7FFF_FFFF);
    return sample_t'(32'h8000_0000);
  endfunction

  // One register write; the scoreboard sees the same value.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic write_all(bit en, logic [CFG_W-1:0] p, logic [CFG_W-1:0] k,
                           logic [CFG_W-1:0] r);
    write_reg(CFG_POLE_GAIN, p);
    write_reg(CFG_STAGE_FEEDBACK, k);
    write_reg(CFG_RESONANCE_GAIN, r);
    write_reg(CFG_ENABLE, {31'b0, en});
    settings_count++;
  endtask

  // Present one request and hold it until the block takes it. The payload
  // stays put while stalled; a gap afterwards drops valid for a while.
  task automatic send_sample(sample_t x);
    int n;
    @(negedge clk);
    in_valid  = 1'b1;
    sample_in = x;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_sample(x);
    sent++;
    n = gap_len();
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Let every outstanding result drain so the registers can be rewritten.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_settings();
    int  mode;
    logic [CFG_W-1:0] p, k, r;
    bit  en;
    mode = $urandom_range(0, 99);
    en   = 1'b1;
    if (mode < 10) begin
      en = 1'b0;
      p  = $urandom;
      k  = $urandom;
      r  = $urandom;
    end else if (mode < 25) begin
      // Full-width data, so the register masks see every bit.
      p = $urandom;
      k = $urandom;
      r = $urandom;
    end else if (mode < 35) begin
      case ($urandom_range(0, 2))
        0: p = 32'd0;
        1: p = 32'd131072;
        default: p = 32'h0003_FFFF;
      endcase
      case ($urandom_range(0, 2))
        0: k = 32'hFFFE_0000;
        1: k = 32'd131072;
        default: k = 32'd0;
      endcase
      case ($urandom_range(0, 2))
        0: r = 32'h8000_0000;
        1: r = 32'h7FFF_FFFF;
        default: r = 32'd0;
      endcase
    end else begin
      // Settings in the range a synthesizer would use.
      p = $urandom_range(0, 32'h10000);
      k = int'($urandom_range(0, 32'h20000)) - 32'sh10000;
      r = int'($urandom_range(0, 32'h80000)) - 32'sh40000;
    end
    write_all(en, p, k, r);
  endtask

  // Output side: stall in random stretches, with calm periods in between.
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_sample(sample_out);
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("ladder_lowpass_filter test failed");
    $finish;
  end

  initial begin
    int len;
    sb             = new();
    settings_count = 0;
    sent           = 0;
    steady         = 1'b0;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = CFG_ENABLE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    sample_in      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Registers at their reset values: the filter is off, so the samples,
    // extremes included, must come back unchanged.
    send_sample(sample_t'(32'h7FFF_FFFF));
    send_sample(sample_t'(32'h8000_0000));
    send_sample('0);
    send_sample(sample_t'(32'hFFFF_FFFF));
    send_sample(sample_t'(32'h1234_5678));
    settle();

    // Impulse response with strong resonance feedback, then full-scale
    // samples that push the cubic clip into wrap-around.
    write_all(1'b1, 32'h4000, 32'hFFFF_8000, 32'h2_0000);
    send_sample(sample_t'(32'h1_0000));
    send_sample('0);
    send_sample('0);
    send_sample('0);
    send_sample(sample_t'(32'h7FFF_FFFF));
    send_sample(sample_t'(32'h8000_0000));
    send_sample(sample_t'(32'h0003_0000));
    settle();

    // Disabling passes samples through and must leave the stage state alone,
    // so filtering resumes where it stopped.
    write_reg(CFG_ENABLE, 32'd0);
    send_sample(sample_t'(32'h5555_AAAA));
    send_sample(sample_t'(32'hAAAA_5555));
    settle();
    write_reg(CFG_ENABLE, 32'd1);
    send_sample(sample_t'(32'hFFFF_0000));
    send_sample('0);
    settle();

    // Coefficient extremes.
    write_all(1'b1, 32'd131072, 32'hFFFE_0000, 32'h8000_0000);
    send_sample(sample_t'(32'h7FFF_FFFF));
    send_sample(sample_t'(32'h8000_0000));
    send_sample(sample_t'(32'h0001_0000));
    settle();
    write_all(1'b1, 32'd0, 32'd131072, 32'h7FFF_FFFF);
    send_sample(sample_t'(32'h8000_0000));
    send_sample(sample_t'(32'h7FFF_FFFF));
    send_sample('0);
    settle();

    // Random phases, each with fresh settings and its own idling mode.
    while (sent < TARGET_REQS) begin
      steady = ($urandom_range(0, 99) < 20);
      random_settings();
      len = $urandom_range(20, 120);
      repeat (len) send_sample(pick_sample());
      settle();
    end
    steady = 1'b0;

    // Extra cycles to catch any output that should not be there.
    repeat (50) @(posedge clk);

    $display("Covered %0d samples (%0d filtered, %0d passed through) over %0d settings.",
             sent, sb.filtered, sb.passed_through, settings_count);
    $display("Compared %0d output samples, %0d mismatches.", sb.compared, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ladder_lowpass_filter test passed");
    end else begin
      $display("ladder_lowpass_filter test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/llf_pkg.sv
hw/rtl/llf_datapath.sv
hw/rtl/llf_ctrl.sv
hw/rtl/ladder_lowpass_filter.sv
test/tb_top.sv
